>>> rtl/lsb_stego_message_extractor_unit_assert.svh
`ifndef LSB_STEGO_MESSAGE_EXTRACTOR_UNIT_ASSERT_SVH
`define LSB_STEGO_MESSAGE_EXTRACTOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define LSME_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define LSME_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/lsme_pkg.sv
package lsme_pkg;

  localparam int unsigned PixW    = 8;
  localparam int unsigned MarkerW = 32;
  localparam int unsigned CountW  = 3;
  localparam int unsigned HeldIdxW = 2;
  localparam logic [MarkerW-1:0] MarkerReset = 32'h4024_2440;

  typedef logic [MarkerW-1:0] marker_t;
  typedef logic [PixW-1:0]    char_t;

  // decoder state carried from one word to the next
  typedef struct packed {
    logic [6:0]        gather;
    logic [CountW-1:0] cnt;
    logic [CountW-1:0] match;
    logic              done;
  } dec_state_t;

  // everything one pixel word causes on the result side
  typedef struct packed {
    logic [CountW-1:0] held_cnt;
    logic              has_char;
    char_t             ch;
    logic              has_term;
    logic              found;
  } job_t;

  function automatic char_t marker_byte(marker_t pat, logic [HeldIdxW-1:0] idx);
    char_t b;
    unique case (idx)
      2'd0: b = pat[31:24];
      2'd1: b = pat[23:16];
      2'd2: b = pat[15:8];
      default: b = pat[7:0];
    endcase
    return b;
  endfunction

endpackage

>>> rtl/lsme_if.sv
interface lsme_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       last_pixel;

  modport source (output valid, output pixel, output last_pixel, input ready);
  modport sink (input valid, input pixel, input last_pixel, output ready);
endinterface

interface lsme_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       is_char;
  logic       last;
  logic       marker_found;

  modport source (output valid, output character, output is_char, output last,
                  output marker_found, input ready);
  modport sink (input valid, input character, input is_char, input last,
                input marker_found, output ready);
endinterface

>>> rtl/lsme_step.sv
module lsme_step #(
  parameter int unsigned MarkerLen = 4
) (
  input  lsme_pkg::dec_state_t st_i,
  input  lsme_pkg::marker_t    marker_i,
  input  logic                 bit_i,
  input  logic                 last_pixel_i,
  output lsme_pkg::dec_state_t st_o,
  output lsme_pkg::job_t       job_o
);
  import lsme_pkg::*;

  char_t             ch;
  logic [CountW-1:0] mc;
  logic [CountW-1:0] mcn;
  logic              term;

  assign ch = {st_i.gather, bit_i};
  assign mc = st_i.match;

  always_comb begin
    st_o  = st_i;
    job_o = '0;
    mcn   = mc;
    term  = 1'b0;
    if (!st_i.done) begin
      if (st_i.cnt == 3'd7) begin
        st_o.gather = '0;
        st_o.cnt    = '0;
        if (mc == '0) begin
          if (ch == marker_byte(marker_i, 2'd0)) begin
            mcn = 3'd1;
          end else begin
            job_o.has_char = 1'b1;
            job_o.ch       = ch;
          end
        end else if (ch == marker_byte(marker_i, mc[HeldIdxW-1:0])) begin
          mcn = mc + 3'd1;
        end else begin
          // mismatch: flush the held prefix, then this character
          job_o.held_cnt = mc;
          job_o.has_char = 1'b1;
          job_o.ch       = ch;
          mcn            = '0;
        end
        if (mcn == CountW'(MarkerLen)) begin
          mcn            = '0;
          st_o.done      = 1'b1;
          job_o.has_term = 1'b1;
          job_o.found    = 1'b1;
          term           = 1'b1;
        end
      end else begin
        st_o.gather = {st_i.gather[5:0], bit_i};
        st_o.cnt    = st_i.cnt + 3'd1;
      end
      if (last_pixel_i && !term) begin
        if (mcn != '0) begin
          job_o.held_cnt = mcn;
        end
        mcn            = '0;
        st_o.gather    = '0;
        st_o.cnt       = '0;
        st_o.done      = 1'b1;
        job_o.has_term = 1'b1;
        job_o.found    = 1'b0;
      end
      st_o.match = mcn;
    end
  end

endmodule

>>> rtl/lsb_stego_message_extractor_unit.sv
// Pulls message characters out of the pixel LSBs, eight pixel words per character,
// first bit into bit 7, and holds back characters that may start the end marker.
// A pixel word is taken in every cycle as long as the second slot of the two-deep
// result queue is free; the decoder state updates in the accept cycle. Results
// leave one per cycle while the receiver is ready: a word that flushes a held marker
// prefix yields up to MARKER_LEN+1 results and occupies its queue slot until all
// have left, stalling input only when both slots hold pending results. After the
// terminator (marker seen, or last_pixel) all pixel words are taken and dropped
// until reset.
module lsb_stego_message_extractor_unit #(
  parameter int unsigned MARKER_LEN = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  lsme_pkg::marker_t   cfg_wdata_i,
  lsme_pixel_if.sink          pix_i,
  lsme_result_if.source       res_o
);
  import lsme_pkg::*;

  marker_t              marker_q;
  dec_state_t           st_q, st_d;
  job_t                 new_job;
  job_t                 h_q, s_q;
  logic                 h_vld_q, s_vld_q;
  logic [HeldIdxW-1:0]  hi_q;

  logic accept, new_any, pop, pop_last, head_free;
  logic kind_held;

  lsme_step #(
    .MarkerLen(MARKER_LEN)
  ) u_step (
    .st_i        (st_q),
    .marker_i    (marker_q),
    .bit_i       (pix_i.pixel[0]),
    .last_pixel_i(pix_i.last_pixel),
    .st_o        (st_d),
    .job_o       (new_job)
  );

  assign pix_i.ready = !s_vld_q;
  assign accept      = pix_i.valid && pix_i.ready;
  assign new_any     = new_job.has_char || new_job.has_term;

  assign kind_held = {1'b0, hi_q} < h_q.held_cnt;
  assign pop       = h_vld_q && res_o.ready;
  always_comb begin
    if (kind_held) begin
      pop_last = ({1'b0, hi_q} + 3'd1 == h_q.held_cnt) && !h_q.has_char && !h_q.has_term;
    end else if (h_q.has_char) begin
      pop_last = !h_q.has_term;
    end else begin
      pop_last = 1'b1;
    end
  end
  assign head_free = !h_vld_q || (pop && pop_last);

  assign res_o.valid        = h_vld_q;
  assign res_o.character    = kind_held ? marker_byte(marker_q, hi_q)
                            : (h_q.has_char ? h_q.ch : '0);
  assign res_o.is_char      = kind_held || h_q.has_char;
  assign res_o.last         = !kind_held && !h_q.has_char;
  assign res_o.marker_found = !kind_held && !h_q.has_char && h_q.found;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= MarkerReset;
    end else if (cfg_we_i) begin
      marker_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= '0;
      h_q     <= '0;
      s_q     <= '0;
      h_vld_q <= 1'b0;
      s_vld_q <= 1'b0;
      hi_q    <= '0;
    end else begin
      if (accept) begin
        st_q <= st_d;
      end
      if (head_free) begin
        hi_q <= '0;
        // ready is low while the spare is full, so no new word lands here then
        if (s_vld_q) begin
          h_q     <= s_q;
          h_vld_q <= 1'b1;
          s_vld_q <= 1'b0;
        end else if (accept && new_any) begin
          h_q     <= new_job;
          h_vld_q <= 1'b1;
        end else begin
          h_vld_q <= 1'b0;
        end
      end else begin
        if (pop) begin
          if (kind_held) begin
            hi_q <= hi_q + 2'd1;
          end else begin
            h_q.has_char <= 1'b0;
          end
        end
        if (accept && new_any) begin
          s_q     <= new_job;
          s_vld_q <= 1'b1;
        end
      end
    end
  end

`include "lsb_stego_message_extractor_unit_assert.svh"

  `LSME_ASSERT_NOW(a_spare_needs_head, clk_i, rst_ni, s_vld_q, h_vld_q)
  `LSME_ASSERT_NOW(a_held_idx_range, clk_i, rst_ni, h_vld_q, ({1'b0, hi_q} <= h_q.held_cnt))
  `LSME_ASSERT_NEXT(a_silent_after_done, clk_i, rst_ni,
                    st_q.done && !h_vld_q && !s_vld_q, !h_vld_q)

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lsme_pkg::*;

  localparam int unsigned MarkerLen     = 4;
  localparam int unsigned SettleCycles  = 20;
  localparam int unsigned SqueezeCycles = 300;

  typedef struct packed {
    char_t character;
    logic  is_char;
    logic  last;
    logic  found;
  } result_word_t;

  // tracks the decoder and holds the result words it still owes
  class decode_scoreboard;
    marker_t      pattern;
    logic [6:0]   gather;
    int unsigned  nbits;
    int unsigned  held;
    bit           msg_done;
    result_word_t want_q[$];
    int unsigned  errors;

    function new();
      pattern  = MarkerReset;
      gather   = '0;
      nbits    = 0;
      held     = 0;
      msg_done = 1'b0;
      errors   = 0;
    endfunction

    function void set_marker(marker_t value);
      pattern = value;
    endfunction

    function char_t pattern_byte(int unsigned idx);
      return pattern[31 - 8 * idx -: 8];
    endfunction

    function void push_word(char_t ch, logic is_char, logic last, logic found);
      result_word_t w;
      w.character = ch;
      w.is_char   = is_char;
      w.last      = last;
      w.found     = found;
      want_q.push_back(w);
    endfunction

    // held prefix goes out as the bytes of the current pattern
    function void flush_held();
      for (int unsigned i = 0; i < held; i++) push_word(pattern_byte(i), 1'b1, 1'b0, 1'b0);
      held = 0;
    endfunction

    function void take_pixel(char_t pixel, logic last_pixel);
      char_t ch;
      if (msg_done) return;
      if (nbits == 7) begin
        ch     = {gather, pixel[0]};
        gather = '0;
        nbits  = 0;
        if (held == 0) begin
          if (ch == pattern_byte(0)) held = 1;
          else push_word(ch, 1'b1, 1'b0, 1'b0);
        end else if (ch == pattern_byte(held)) begin
          held++;
        end else begin
          // restart at zero without rechecking this character
          flush_held();
          push_word(ch, 1'b1, 1'b0, 1'b0);
        end
        if (held >= MarkerLen) begin
          held     = 0;
          msg_done = 1'b1;
          push_word(8'h00, 1'b0, 1'b1, 1'b1);
          return;
        end
      end else begin
        gather = {gather[5:0], pixel[0]};
        nbits++;
      end
      if (last_pixel) begin
        flush_held();
        gather   = '0;
        nbits    = 0;
        msg_done = 1'b1;
        push_word(8'h00, 1'b0, 1'b1, 1'b0);
      end
    endfunction

    function bit would_finish(char_t ch);
      return !msg_done && nbits == 0 && held == MarkerLen - 1 && ch == pattern_byte(held);
    endfunction

    function void compare_field(string fname, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      end
    endfunction

    function void check_word(result_word_t got);
      result_word_t want;
      if (want_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual %h", $time, got);
        return;
      end
      want = want_q.pop_front();
      compare_field("character", want.character, got.character);
      compare_field("is_char", 8'(want.is_char), 8'(got.is_char));
      compare_field("last", 8'(want.last), 8'(got.last));
      compare_field("marker_found", 8'(want.found), 8'(got.found));
    endfunction
  endclass

  logic    clk_i;
  logic    rst_ni;
  logic    cfg_we_i;
  marker_t cfg_wdata_i;

  lsme_pixel_if  pix_bus();
  lsme_result_if res_bus();

  lsb_stego_message_extractor_unit #(
    .MARKER_LEN(MarkerLen)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pix_i      (pix_bus),
    .res_o      (res_bus)
  );

  decode_scoreboard sb;
  bit sender_calm;
  bit receiver_calm;
  bit squeeze;
  bit got_pending;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_pixel(char_t pixel, logic last_pixel);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk_i);
      pix_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    pix_bus.valid      <= 1'b1;
    pix_bus.pixel      <= pixel;
    pix_bus.last_pixel <= last_pixel;
    do @(posedge clk_i); while (!pix_bus.ready);
    sb.take_pixel(pixel, last_pixel);
  endtask

  task automatic pixel_idle();
    @(negedge clk_i);
    pix_bus.valid <= 1'b0;
  endtask

  // first bit of the character rides in the first pixel word
  task automatic send_char(char_t ch, logic last_pixel);
    char_t pixel;
    for (int i = 7; i >= 0; i--) begin
      pixel    = char_t'($urandom);
      pixel[0] = ch[i];
      send_pixel(pixel, last_pixel && i == 0);
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  // held prefixes make no result words, so drain the owed words and then give the block spare time
  task automatic settle();
    pixel_idle();
    while (sb.want_q.size() != 0 || got_pending) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_marker(marker_t value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.set_marker(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // keep the message open until the final stretch
  function automatic char_t safe_char(char_t ch);
    return sb.would_finish(ch) ? (ch ^ 8'h01) : ch;
  endfunction

  task automatic random_step();
    int unsigned mode;
    int unsigned len;
    mode = $urandom_range(0, 99);
    if (mode < 45) begin
      len = $urandom_range(1, MarkerLen - 1);
      for (int unsigned i = 0; i < len; i++) send_char(safe_char(sb.pattern_byte(i)), 1'b0);
      send_char(safe_char(char_t'($urandom)), 1'b0);
    end else if (mode < 60) begin
      send_char(safe_char(sb.pattern_byte($urandom_range(0, MarkerLen - 1))), 1'b0);
    end else begin
      send_char(safe_char(char_t'($urandom)), 1'b0);
    end
  endtask

  initial begin : result_sink
    result_word_t got;
    int unsigned  stall;
    res_bus.ready = 1'b0;
    got_pending   = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (squeeze) begin
        squeeze = 1'b0;
        stall   = SqueezeCycles;
      end else if (receiver_calm) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 9);
      end
      for (int unsigned k = 0; k <= stall; k++) begin
        @(negedge clk_i);
        // checked late, once the pixel side has noted its word
        if (got_pending) begin
          sb.check_word(got);
          got_pending = 1'b0;
        end
        res_bus.ready <= (k == stall);
      end
      do @(posedge clk_i); while (!(res_bus.valid && res_bus.ready));
      got = {res_bus.character, res_bus.is_char, res_bus.last, res_bus.marker_found};
      got_pending = 1'b1;
    end
  end

  initial begin : stimulus
    int unsigned ending;
    marker_t     next_marker;
    sb                 = new();
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    pix_bus.valid      = 1'b0;
    pix_bus.pixel      = '0;
    pix_bus.last_pixel = 1'b0;
    sender_calm        = 1'b0;
    receiver_calm      = 1'b0;
    squeeze            = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_marker(MarkerReset);
    repeat (8) send_pixel(8'hFF, 1'b0);
    repeat (8) send_pixel(8'h00, 1'b0);
    send_text("@$X");
    send_text("@@");
    send_text("@$$A");
    // leave a prefix held across a pattern change
    send_text("@$");
    settle();
    write_marker(32'h1122_3344);
    send_text("Z");

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: next_marker = 32'h0000_0000;
        1: next_marker = 32'hFFFF_FFFF;
        3: next_marker = MarkerReset;
        4: next_marker = 32'h4141_4142;
        default: next_marker = marker_t'($urandom);
      endcase
      write_marker(next_marker);
      sender_calm   = ($urandom_range(0, 3) == 0);
      receiver_calm = ($urandom_range(0, 3) == 0);
      if (ph == 2) squeeze = 1'b1;
      repeat (5) random_step();
    end

    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    ending = $urandom_range(0, 3);
    case (ending)
      0, 1: begin
        while (!sb.msg_done)
          send_char(sb.pattern_byte(sb.held), (ending == 1) && (sb.held == MarkerLen - 1));
      end
      default: begin
        repeat ($urandom_range(0, MarkerLen - 1))
          if (sb.held < MarkerLen - 1) send_char(sb.pattern_byte(sb.held), 1'b0);
        if (ending == 2) begin
          // image ends inside a character
          repeat ($urandom_range(0, 6)) send_pixel(char_t'($urandom), 1'b0);
          send_pixel(char_t'($urandom), 1'b1);
        end else begin
          send_char(safe_char(char_t'($urandom)), 1'b1);
        end
      end
    endcase

    // everything after the terminator is dropped
    repeat (20) send_pixel(char_t'($urandom), 1'($urandom_range(0, 1)));
    pixel_idle();

    while (sb.want_q.size() != 0 || got_pending) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (sb.errors == 0 && sb.want_q.size() == 0 && !got_pending) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
